/* rtl/fbd_pkg.sv */
`timescale 1ns / 1ps

package fbd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SIZE_W        = 7;
    localparam int SRC_W         = 22;
    localparam int ORATE_W       = 18;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 22;
    localparam int BIT_STEP_W    = $clog2(SAMPLE_W);
    localparam int SRC_STEP_W    = $clog2(SRC_W);
    localparam int MAX_SLICE_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [SRC_W-1:0]   SRC_RATE_RESET = SRC_W'(21477272 / 12);
    localparam logic [ORATE_W-1:0] OUT_RATE_RESET = ORATE_W'(44100);

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = CFG_IDX_W'(1);

    typedef struct packed {
        logic               busy;
        logic               zero;
        logic [ORATE_W-1:0] orate;
        logic [ORATE_W-1:0] orate_m1;
        logic [SRC_W-1:0]   quo;
        logic [ORATE_W-1:0] rem;
    } ratio_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_HOLD
    } back_state_t;

endpackage

/* rtl/fbd_ratio.sv */
`timescale 1ns / 1ps

module fbd_ratio
    import fbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output ratio_t                rs
);

    logic [SRC_W-1:0]      src_reg, src_next;
    logic [ORATE_W-1:0]    orate_reg, orate_next;
    logic [SRC_W-1:0]      quo_reg, quo_next;
    logic [ORATE_W-1:0]    rem_reg, rem_next;
    logic [SRC_STEP_W-1:0] cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic                  run_reg, run_next;
    logic [ORATE_W:0]      sh;
    logic [ORATE_W:0]      diff;
    logic                  ge;

    always_comb
    begin
        sh   = {rem_reg, quo_reg[SRC_W-1]};
        diff = sh - {1'b0, orate_reg};
        ge   = (sh >= {1'b0, orate_reg});
    end

    always_comb
    begin
        src_next   = src_reg;
        orate_next = orate_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        run_next   = run_reg;
        if (cfg_we)
        begin
            priority if (cfg_index == REG_SOURCE_RATE)
            begin
                src_next  = cfg_data[SRC_W-1:0];
                pend_next = 1'b1;
            end
            else if (cfg_index == REG_OUTPUT_RATE)
            begin
                orate_next = cfg_data[ORATE_W-1:0];
                pend_next  = 1'b1;
            end
            else
            begin
                pend_next = pend_reg;
            end
        end
        else if (pend_reg)
        begin
            quo_next  = src_reg;
            rem_next  = '0;
            cnt_next  = '0;
            pend_next = 1'b0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[ORATE_W-1:0] : sh[ORATE_W-1:0];
            quo_next = {quo_reg[SRC_W-2:0], ge};
            if (cnt_reg == SRC_STEP_W'(SRC_W - 1))
            begin
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg   <= SRC_RATE_RESET;
            orate_reg <= OUT_RATE_RESET;
            cnt_reg   <= '0;
            pend_reg  <= 1'b1;
            run_reg   <= 1'b0;
        end
        else
        begin
            src_reg   <= src_next;
            orate_reg <= orate_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        rs.busy     = pend_reg | run_reg;
        rs.zero     = (orate_reg == '0);
        rs.orate    = orate_reg;
        rs.orate_m1 = orate_reg - 1'b1;
        rs.quo      = quo_reg;
        rs.rem      = rem_reg;
    end

endmodule

/* rtl/fbd_front.sv */
`timescale 1ns / 1ps

module fbd_front
    import fbd_pkg::*;
#(
    parameter int MAX_SLICE = MAX_SLICE_DEF,
    parameter int CNT_W     = $clog2(MAX_SLICE + 1),
    parameter int SUM_W     = SAMPLE_W + $clog2(MAX_SLICE)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ratio_t              rs,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  logic                q_full,
    output logic                push,
    output logic [CNT_W+SUM_W-1:0] push_data
);

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_SLICE);

    logic [ORATE_W-1:0] phase_reg, phase_next;
    logic               acc_valid_reg, acc_valid_next;
    logic [ORATE_W:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic               cand_valid_reg, cand_valid_next;
    logic [CNT_W-1:0]   cand_len_reg, cand_len_next;
    logic [ORATE_W-1:0] cand_phase_reg, cand_phase_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   taken_reg, taken_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    logic               accept;
    logic               first;
    logic [CNT_W-1:0]   len_cur;
    logic [CNT_W-1:0]   cnt_new;
    logic [SUM_W-1:0]   sum_new;
    logic               done;
    logic [ORATE_W-1:0] acc0;
    logic [ORATE_W:0]   acc_diff;
    logic               acc_ge;

    assign first    = (taken_reg == '0);
    assign in_ready = !q_full && (!first || (cand_valid_reg && !rs.busy));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        len_cur   = first ? cand_len_reg : len_reg;
        cnt_new   = first ? CNT_W'(1) : taken_reg + 1'b1;
        sum_new   = (first ? '0 : sum_reg) + SUM_W'(sample_in);
        done      = (cnt_new >= len_cur);
        push      = accept && done;
        push_data = {cnt_new, sum_new};
    end

    always_comb
    begin
        acc0     = (phase_reg >= rs.orate) ? rs.orate_m1 : phase_reg;
        acc_diff = acc_reg - {1'b0, rs.orate};
        acc_ge   = (acc_reg >= {1'b0, rs.orate});
    end

    always_comb
    begin
        phase_next      = phase_reg;
        acc_valid_next  = acc_valid_reg;
        acc_next        = acc_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        cand_valid_next = cand_valid_reg;
        cand_len_next   = cand_len_reg;
        cand_phase_next = cand_phase_reg;
        len_next        = len_reg;
        taken_next      = taken_reg;
        sum_next        = sum_reg;

        if (accept)
        begin
            if (first)
            begin
                len_next   = cand_len_reg;
                phase_next = cand_phase_reg;
            end
            if (done)
            begin
                taken_next = '0;
            end
            else
            begin
                taken_next = cnt_new;
                sum_next   = sum_new;
            end
        end

        // The next slice length is prepared ahead in two steps and is
        // committed only when the first sample of the slice arrives.
        if (rs.busy || (accept && first))
        begin
            acc_valid_next  = 1'b0;
            cand_valid_next = 1'b0;
        end
        else if (!acc_valid_reg)
        begin
            acc_next       = {1'b0, acc0} + {1'b0, rs.rem};
            lo_next        = (rs.quo == '0) ? CNT_W'(1) :
                             ((rs.quo >= SRC_W'(MAX_SLICE)) ? MAX_LEN : CNT_W'(rs.quo));
            hi_next        = (rs.quo >= SRC_W'(MAX_SLICE)) ? MAX_LEN :
                             CNT_W'(rs.quo) + 1'b1;
            acc_valid_next = 1'b1;
        end
        else if (!cand_valid_reg)
        begin
            if (rs.zero)
            begin
                cand_len_next   = MAX_LEN;
                cand_phase_next = phase_reg;
            end
            else
            begin
                cand_len_next   = acc_ge ? hi_reg : lo_reg;
                cand_phase_next = acc_ge ? acc_diff[ORATE_W-1:0] : acc_reg[ORATE_W-1:0];
            end
            cand_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            acc_valid_reg  <= 1'b0;
            cand_valid_reg <= 1'b0;
            taken_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            acc_valid_reg  <= acc_valid_next;
            cand_valid_reg <= cand_valid_next;
            taken_reg      <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        cand_len_reg   <= cand_len_next;
        cand_phase_reg <= cand_phase_next;
        len_reg        <= len_next;
        sum_reg        <= sum_next;
    end

endmodule

/* rtl/fbd_queue.sv */
`timescale 1ns / 1ps

module fbd_queue
    import fbd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

/* rtl/fbd_back.sv */
`timescale 1ns / 1ps

module fbd_back
    import fbd_pkg::*;
#(
    parameter int MAX_SLICE = MAX_SLICE_DEF,
    parameter int CNT_W     = $clog2(MAX_SLICE + 1),
    parameter int SUM_W     = SAMPLE_W + $clog2(MAX_SLICE)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic [CNT_W+SUM_W-1:0] q_data,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_W-1:0]    mean_sample,
    output logic [SIZE_W-1:0]      slice_size
);

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [SAMPLE_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]      div_reg, div_next;
    logic [BIT_STEP_W-1:0] step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]   mean_reg, mean_next;
    logic [SIZE_W-1:0]     size_reg, size_next;

    logic             load;
    logic             step;
    logic             wr_out;
    logic             last_step;
    logic [CNT_W:0]   sh;
    logic [CNT_W:0]   diff;
    logic             ge;
    logic [CNT_W-1:0] q_cnt;
    logic [SUM_W-1:0] q_sum;

    assign q_cnt     = q_data[CNT_W+SUM_W-1:SUM_W];
    assign q_sum     = q_data[SUM_W-1:0];
    assign last_step = (step_reg == BIT_STEP_W'(SAMPLE_W - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (last_step)
                begin
                    state_next = B_HOLD;
                end
            end
            B_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load   = 1'b0;
        step   = 1'b0;
        wr_out = 1'b0;
        unique case (state_reg)
            B_IDLE:  load   = !q_empty;
            B_RUN:   step   = 1'b1;
            B_HOLD:  wr_out = !out_valid_reg || out_ready;
            default: load   = 1'b0;
        endcase
    end

    assign pop = load;

    always_comb
    begin
        sh   = {rem_reg, lo_reg[SAMPLE_W-1]};
        diff = sh - {1'b0, div_reg};
        ge   = (sh >= {1'b0, div_reg});
    end

    always_comb
    begin
        rem_next       = rem_reg;
        lo_next        = lo_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        mean_next      = mean_reg;
        size_next      = size_reg;

        // The upper sum bits are already below the count, so sixteen
        // restoring steps give the whole quotient.
        if (load)
        begin
            rem_next  = CNT_W'(q_sum[SUM_W-1:SAMPLE_W]);
            lo_next   = q_sum[SAMPLE_W-1:0];
            div_next  = q_cnt;
            step_next = '0;
        end
        else if (step)
        begin
            rem_next  = ge ? diff[CNT_W-1:0] : sh[CNT_W-1:0];
            lo_next   = {lo_reg[SAMPLE_W-2:0], ge};
            step_next = step_reg + 1'b1;
        end

        if (wr_out)
        begin
            out_valid_next = 1'b1;
            mean_next      = lo_reg;
            size_next      = SIZE_W'(div_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        div_reg  <= div_next;
        mean_reg <= mean_next;
        size_reg <= size_next;
    end

    assign out_valid   = out_valid_reg;
    assign mean_sample = mean_reg;
    assign slice_size  = size_reg;

endmodule

/* rtl/fractional_boxcar_decimator_top.sv */
`timescale 1ns / 1ps

// Averaging decimator from source_rate to output_rate. Each slice of input samples yields
// one request with the truncated mean and the slice size; slice lengths are chosen between
// the floor and ceiling of the rate ratio, clamped to 1..MAX_SLICE. Within a slice a sample
// is taken every cycle while the slice queue has room. The first sample of a slice is taken
// only once the next slice length has been prepared after the first sample of the previous
// slice, and only once the bit-serial rate divider is no longer busy after reset or after a
// rate register write. The mean is formed by a bit-serial divider behind a two-entry queue;
// the divider takes a new slice only after it has output the previous one, so short slices
// are limited by the divider.
module fractional_boxcar_decimator_top
    import fbd_pkg::*;
#(
    parameter int MAX_SLICE = MAX_SLICE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   sample_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   mean_sample,
    output logic [SIZE_W-1:0]     slice_size
);

    localparam int CNT_W = $clog2(MAX_SLICE + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_SLICE);

    ratio_t                 rs;
    logic                   cfg_we;
    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_empty;
    logic [CNT_W+SUM_W-1:0] push_data;
    logic [CNT_W+SUM_W-1:0] pop_data;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    fbd_ratio u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rs        (rs)
    );

    fbd_front #(
        .MAX_SLICE (MAX_SLICE),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rs        (rs),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_in (sample_in),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    fbd_queue #(
        .WIDTH (CNT_W + SUM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    fbd_back #(
        .MAX_SLICE (MAX_SLICE),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mean_sample (mean_sample),
        .slice_size  (slice_size)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("slice queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("slice queue read while empty");

    a_cfg_restarts_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == REG_SOURCE_RATE || cfg_index == REG_OUTPUT_RATE))
        |=> rs.busy)
        else $error("rate divider not restarted after register write");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_data[CNT_W+SUM_W-1:SUM_W] != '0))
        else $error("finished slice with no samples");

endmodule
